FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the cache RTL.
// Expects clk and rst_n to be visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent required in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sacache_pkg.sv
// Shared geometry, types and helpers for the set-associative cache.
// No dependencies.
`timescale 1ns / 1ps

package sacache_pkg;

    localparam int NUM_SETS    = 64;
    localparam int WAYS        = 4;
    localparam int BLOCK_BYTES = 32;
    localparam int ADDR_BITS   = 32;

    localparam int OFFSET_BITS = $clog2(BLOCK_BYTES);
    localparam int SET_BITS    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - $clog2(NUM_SETS);
    localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_BITS   = WAY_BITS;

    typedef logic [WAYS-1:0][TAG_BITS-1:0]  tag_row_t;
    typedef logic [WAYS-1:0][RANK_BITS-1:0] rank_row_t;

    // One set as held in the line memory
    typedef struct packed {
        tag_row_t          tags;
        logic [WAYS-1:0]   dirty;
        rank_row_t         ranks;
    } set_row_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
    } cache_cmd_t;

    // Ranks of a set that has never been touched: rank equals way number
    function automatic rank_row_t rank_reset();
        rank_row_t r;
        for (int w = 0; w < WAYS; w++)
        begin
            r[w] = RANK_BITS'(w);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/sacache_ctrl.sv
// Access sequencer for the cache: capture cycle, then lookup/update cycle.
// Depends on sacache_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sacache_ctrl
    import sacache_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    output cache_cmd_t cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic state_reg, state_next;
    logic done_reg, done_next;

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.update  = 1'b0;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
        endcase
        done_next = cmd.update;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == ST_LOOKUP);
    assign done = done_reg;

    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
    `ASSERT_NEXT(a_lookup_done, state_reg == ST_LOOKUP, done_reg,
                 "lookup finished without result strobe")
    `ASSERT_NEXT(a_single_done, done_reg, !done_reg, "result strobe held for two cycles")

endmodule

FILE: rtl/core/sacache_dp.sv
// Cache datapath: line memory (tags, dirty, ranks), valid flops, tag compare,
// victim choice, LRU promotion and result registers. Depends on sacache_pkg.
`timescale 1ns / 1ps

module sacache_dp
    import sacache_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cache_cmd_t  cmd,
    input  logic        kind,
    input  logic [31:0] address,
    output logic        hit,
    output logic        fill_request,
    output logic [31:0] fill_address,
    output logic        writeback,
    output logic [31:0] writeback_address
);

    set_row_t line_mem [NUM_SETS];
    set_row_t row_q;

    logic [NUM_SETS-1:0][WAYS-1:0] valid_reg;

    logic                kind_reg;
    logic [SET_BITS-1:0] set_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic [SET_BITS-1:0] set_in;
    logic [TAG_BITS-1:0] tag_in;

    logic [WAYS-1:0]      valid_row;
    rank_row_t            ranks_cur;
    rank_row_t            ranks_new;
    logic [WAYS-1:0]      match;
    logic                 hit_any;
    logic [WAY_BITS-1:0]  hit_way;
    logic [WAY_BITS-1:0]  victim_way;
    logic [WAY_BITS-1:0]  sel_way;
    logic [RANK_BITS-1:0] sel_rank;
    logic                 victim_dirty;
    set_row_t             row_new;
    logic [ADDR_BITS-1:0] fill_block;
    logic [ADDR_BITS-1:0] victim_block;

    assign set_in = SET_BITS'(address[ADDR_BITS-1:OFFSET_BITS]);
    assign tag_in = address[ADDR_BITS-1 -: TAG_BITS];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_q <= line_mem[set_in];
        end
        if (cmd.update)
        begin
            line_mem[set_reg] <= row_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.update)
        begin
            valid_reg[set_reg][sel_way] <= 1'b1;
        end
    end

    always_comb
    begin
        valid_row = valid_reg[set_reg];
        // untouched set: memory row is stale, ranks take their reset order
        ranks_cur = (valid_row == '0) ? rank_reset() : row_q.ranks;

        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = valid_row[w] && (row_q.tags[w] == tag_reg);
        end
        hit_any = |match;

        hit_way    = '0;
        victim_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_BITS'(w);
            end
            if (ranks_cur[w] == RANK_BITS'(WAYS - 1))
            begin
                victim_way = WAY_BITS'(w);
            end
        end

        sel_way  = hit_any ? hit_way : victim_way;
        sel_rank = ranks_cur[sel_way];

        for (int w = 0; w < WAYS; w++)
        begin
            ranks_new[w] = (ranks_cur[w] < sel_rank) ? ranks_cur[w] + 1'b1 : ranks_cur[w];
        end
        ranks_new[sel_way] = '0;

        victim_dirty = valid_row[victim_way] && row_q.dirty[victim_way];

        row_new       = row_q;
        row_new.ranks = ranks_new;
        if (hit_any)
        begin
            row_new.dirty[sel_way] = row_q.dirty[sel_way] | kind_reg;
        end
        else
        begin
            row_new.tags[sel_way]  = tag_reg;
            row_new.dirty[sel_way] = kind_reg;
        end

        fill_block   = {tag_reg, set_reg, OFFSET_BITS'(0)};
        victim_block = {row_q.tags[victim_way], set_reg, OFFSET_BITS'(0)};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            set_reg  <= set_in;
            tag_reg  <= tag_in;
        end
        if (cmd.update)
        begin
            hit               <= hit_any;
            fill_request      <= !hit_any;
            fill_address      <= hit_any ? '0 : 32'(fill_block);
            writeback         <= !hit_any && victim_dirty;
            writeback_address <= (!hit_any && victim_dirty) ? 32'(victim_block) : '0;
        end
    end

endmodule

FILE: rtl/core/set_assoc_lru_writeback_cache.sv
// Top level of the set-associative write-back LRU cache.
// Depends on sacache_pkg, sacache_ctrl, sacache_dp and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Input: drive kind (0 read, 1 write) and address with start high; the
//   transfer is taken at a rising edge where start is high and busy is low.
//   Output: one result per access, shown for a single cycle while done is
//   high: hit, or fill_request with the block-aligned fill_address, plus
//   writeback and writeback_address when a dirty victim is evicted.
//   Sequence: the accepting edge moves the access into the lookup state and
//   done is registered from it; no access is taken in lookup. The set row is
//   read from the line memory at capture, rewritten in lookup, on one port.
//   busy is high for the cycle between acceptance and the result.
//   The receiver cannot stall; each result is valid for its strobe cycle
//   only, and the next access may already be accepted in that cycle.
//   Reset: all ways invalid, clean, ranks equal to way number; no clearing
//   pass is needed, so an access is taken in the first cycle after reset.

module set_assoc_lru_writeback_cache
    import sacache_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [31:0] address,
    output logic        done,
    output logic        hit,
    output logic        fill_request,
    output logic [31:0] fill_address,
    output logic        writeback,
    output logic [31:0] writeback_address
);

    cache_cmd_t cmd;

    sacache_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    sacache_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .kind              (kind),
        .address           (address),
        .hit               (hit),
        .fill_request      (fill_request),
        .fill_address      (fill_address),
        .writeback         (writeback),
        .writeback_address (writeback_address)
    );

    `ASSERT_ALWAYS(a_hit_xor_fill, !done || (hit != fill_request),
                   "result is neither exactly hit nor miss")
    `ASSERT_ALWAYS(a_wb_on_miss, !(done && writeback) || fill_request,
                   "writeback reported on a hit")

endmodule

FILE: tb/set_assoc_lru_writeback_cache_tb.sv
// Self-checking testbench for set_assoc_lru_writeback_cache.
// Holds its own model of tags, valid, dirty and LRU ranks; depends on sacache_pkg
// and the cache RTL.
`timescale 1ns / 1ps

module set_assoc_lru_writeback_cache_tb
    import sacache_pkg::*;
();

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;
    localparam int   STALL_LIMIT = 1000;
    localparam logic [TAG_BITS-1:0] TAG_MAX = {TAG_BITS{1'b1}};

    typedef struct packed {
        logic        hit;
        logic        fill_request;
        logic [31:0] fill_address;
        logic        writeback;
        logic [31:0] writeback_address;
    } access_outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic [31:0] address;
    logic        done;
    logic        hit;
    logic        fill_request;
    logic [31:0] fill_address;
    logic        writeback;
    logic [31:0] writeback_address;

    // Shadow copy of the cache directory
    logic [TAG_BITS-1:0]  shadow_tag   [NUM_SETS][WAYS];
    logic                 shadow_valid [NUM_SETS][WAYS];
    logic                 shadow_dirty [NUM_SETS][WAYS];
    logic [RANK_BITS-1:0] shadow_rank  [NUM_SETS][WAYS];

    access_outcome_t outcomes_due[$];

    int errors;
    int accesses;
    int hit_count;
    int miss_count;
    int evict_count;
    int stall_cycles;

    set_assoc_lru_writeback_cache dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .kind              (kind),
        .address           (address),
        .done              (done),
        .hit               (hit),
        .fill_request      (fill_request),
        .fill_address      (fill_address),
        .writeback         (writeback),
        .writeback_address (writeback_address)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] line_addr(input logic [TAG_BITS-1:0] tg,
                                              input int st, input int ofs);
        return {tg, SET_BITS'(st), OFFSET_BITS'(ofs)};
    endfunction

    // Move one way to most recent; younger ways age by one
    function automatic void make_recent(input int st, input int w);
        logic [RANK_BITS-1:0] r;
        r = shadow_rank[st][w];
        for (int j = 0; j < WAYS; j++)
        begin
            if (shadow_rank[st][j] < r)
                shadow_rank[st][j] = shadow_rank[st][j] + 1'b1;
        end
        shadow_rank[st][w] = '0;
    endfunction

    function automatic access_outcome_t predict_access(input logic k,
                                                       input logic [31:0] a);
        access_outcome_t o;
        logic [TAG_BITS-1:0] tg;
        int st;
        int victim;
        o  = '0;
        tg = a[31 -: TAG_BITS];
        st = int'(a[OFFSET_BITS +: SET_BITS]);
        for (int w = 0; w < WAYS; w++)
        begin
            if (!o.hit && shadow_valid[st][w] && shadow_tag[st][w] == tg)
            begin
                o.hit = 1'b1;
                make_recent(st, w);
                if (k == KIND_WRITE)
                    shadow_dirty[st][w] = 1'b1;
            end
        end
        if (o.hit)
        begin
            hit_count++;
            return o;
        end
        miss_count++;
        victim = -1;
        for (int w = 0; w < WAYS; w++)
        begin
            if (victim < 0 && shadow_rank[st][w] == RANK_BITS'(WAYS - 1))
                victim = w;
        end
        o.fill_request = 1'b1;
        o.fill_address = {a[31:OFFSET_BITS], {OFFSET_BITS{1'b0}}};
        if (shadow_valid[st][victim] && shadow_dirty[st][victim])
        begin
            o.writeback = 1'b1;
            o.writeback_address = line_addr(shadow_tag[st][victim], st, 0);
            evict_count++;
        end
        shadow_tag[st][victim]   = tg;
        shadow_valid[st][victim] = 1'b1;
        shadow_dirty[st][victim] = (k == KIND_WRITE);
        make_recent(st, victim);
        return o;
    endfunction

    // Present one access, hold it until the transfer, then maybe pause
    task automatic issue_access(input logic k, input logic [31:0] a, input int idle_pct);
        int gap;
        start   <= 1'b1;
        kind    <= k;
        address <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        outcomes_due.push_back(predict_access(k, a));
        accesses++;
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            gap = $urandom_range(4, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Field extremes, hit promotion, clean and dirty victims, top-of-range tags
    task automatic test_directed();
        issue_access(KIND_READ,  line_addr('0, 0, 0), 0);
        issue_access(KIND_READ,  line_addr('0, 0, 31), 0);
        issue_access(KIND_WRITE, line_addr('0, 0, 16), 0);
        issue_access(KIND_WRITE, 32'hFFFF_FFFF, 0);
        issue_access(KIND_READ,  line_addr(1, 0, 4), 0);
        issue_access(KIND_READ,  line_addr(2, 0, 8), 0);
        issue_access(KIND_READ,  line_addr(3, 0, 12), 0);
        issue_access(KIND_READ,  line_addr(1, 0, 0), 0);
        issue_access(KIND_READ,  line_addr(4, 0, 0), 0);
        issue_access(KIND_READ,  line_addr(5, 0, 0), 0);
        issue_access(KIND_WRITE, line_addr(3, 0, 0), 0);
        issue_access(KIND_READ,  line_addr(6, 0, 0), 0);
        issue_access(KIND_WRITE, line_addr(0, 63, 0), 0);
        issue_access(KIND_WRITE, line_addr(1, 63, 0), 0);
        issue_access(KIND_WRITE, line_addr(2, 63, 0), 0);
        issue_access(KIND_READ,  line_addr(3, 63, 31), 0);
        issue_access(KIND_WRITE, line_addr(TAG_MAX, 0, 1), 0);
        issue_access(KIND_READ,  32'h0000_0000, 0);
        issue_access(KIND_WRITE, line_addr(5, 0, 0), 0);
        issue_access(KIND_READ,  line_addr(2, 63, 0), 0);
        issue_access(KIND_WRITE, 32'h5555_5555, 0);
        issue_access(KIND_WRITE, 32'hAAAA_AAAA, 0);
    endtask

    // Few hot sets, more tags than ways: mixes hits, clean and dirty evictions
    task automatic test_hits_and_evictions(input int idle_pct, input int n);
        int hot_sets [4];
        logic [TAG_BITS-1:0] tag_pool [7];
        logic [31:0] a;
        for (int i = 0; i < 4; i++)
            hot_sets[i] = $urandom_range(NUM_SETS - 1, 0);
        for (int i = 0; i < 7; i++)
            tag_pool[i] = TAG_BITS'($urandom());
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99, 0) < 85)
                a = line_addr(tag_pool[$urandom_range(6, 0)],
                              hot_sets[$urandom_range(3, 0)],
                              $urandom_range(BLOCK_BYTES - 1, 0));
            else
                a = $urandom();
            issue_access(logic'($urandom_range(1, 0)), a, idle_pct);
        end
    endtask

    // Addresses spread over the whole space, mostly cold misses
    task automatic test_scattered(input int idle_pct, input int n);
        for (int i = 0; i < n; i++)
            issue_access(logic'($urandom_range(1, 0)), $urandom(), idle_pct);
    endtask

    always @(posedge clk)
    begin
        access_outcome_t exp_o;
        if (rst_n && done)
        begin
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: result with no access outstanding", $time);
                errors++;
            end
            else
            begin
                exp_o = outcomes_due.pop_front();
                if (hit !== exp_o.hit)
                begin
                    $display("%0t: hit exp %0b got %0b", $time, exp_o.hit, hit);
                    errors++;
                end
                if (fill_request !== exp_o.fill_request)
                begin
                    $display("%0t: fill_request exp %0b got %0b", $time,
                             exp_o.fill_request, fill_request);
                    errors++;
                end
                if (fill_address !== exp_o.fill_address)
                begin
                    $display("%0t: fill_address exp %h got %h", $time,
                             exp_o.fill_address, fill_address);
                    errors++;
                end
                if (writeback !== exp_o.writeback)
                begin
                    $display("%0t: writeback exp %0b got %0b", $time,
                             exp_o.writeback, writeback);
                    errors++;
                end
                if (writeback_address !== exp_o.writeback_address)
                begin
                    $display("%0t: writeback_address exp %h got %h", $time,
                             exp_o.writeback_address, writeback_address);
                    errors++;
                end
            end
        end
    end

    // Cycles without any transfer in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 outcomes_due.size());
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = KIND_READ;
        address      = '0;
        accesses     = 0;
        hit_count    = 0;
        miss_count   = 0;
        evict_count  = 0;
        for (int s = 0; s < NUM_SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                shadow_tag[s][w]   = '0;
                shadow_valid[s][w] = 1'b0;
                shadow_dirty[s][w] = 1'b0;
                shadow_rank[s][w]  = RANK_BITS'(w);
            end
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_hits_and_evictions(8, 140);
        test_scattered(8, 25);
        test_hits_and_evictions(59, 140);
        test_scattered(59, 25);
        test_hits_and_evictions(0, 140);
        test_scattered(0, 25);

        start <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        // wait on so that any stray strobe is caught
        repeat (6) @(posedge clk);

        $display("Ran %0d accesses: %0d hits, %0d misses, %0d dirty evictions,",
                 accesses, hit_count, miss_count, evict_count);
        $display("with sender pauses at 8%%, 59%% and none; %0d mismatches", errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
